// File: src/mrtu_pkg.sv
// ----------------------------------------------------------------------------
// mrtu_pkg
// Shared types, constants and the crc-16/modbus byte update for the codec.
// ----------------------------------------------------------------------------
package mrtu_pkg;

  localparam int PDU_MAX     = 253;
  localparam int ADU_MIN     = 4;
  localparam int ADU_MAX     = 256;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [8:0]  COUNT_SAT = 9'h1FF;
  localparam logic [8:0]  CAP_RESET = 9'd256;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_LEN = 2'd1;
  localparam logic [1:0] ST_CAP = 2'd2;
  localparam logic [1:0] ST_CRC = 2'd3;

  localparam logic CMD_ENCODE = 1'b0;
  localparam logic CMD_DECODE = 1'b1;

  typedef struct packed {
    logic       command;
    logic [7:0] data_byte;
    logic [7:0] unit_id;
    logic       last_item;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic [1:0] status;
    logic [7:0] frame_unit_id;
    logic [7:0] frame_pdu_length;
  } out_item_t;

  // one classified input byte handed from front to back
  typedef struct packed {
    logic        mode;
    logic        first;
    logic        last;
    logic [7:0]  data;
    logic [7:0]  uid;
    logic [8:0]  count;
    logic        feed_en;
    logic [7:0]  feed_byte;
    logic [15:0] rx_crc;
    logic [7:0]  first_byte;
  } job_t;

  function automatic logic [15:0] crc_feed(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (r[0]) begin
        r = (r >> 1) ^ CRC_POLY;
      end else begin
        r = r >> 1;
      end
    end
    return r;
  endfunction

endpackage

// File: src/mrtu_front.sv
// ----------------------------------------------------------------------------
// mrtu_front
// Tracks frame position per input byte and builds a job for the back end.
// ----------------------------------------------------------------------------
module mrtu_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  mrtu_pkg::in_item_t item,
  output mrtu_pkg::job_t    job
);
  import mrtu_pkg::*;

  logic       in_frame;
  logic       frame_mode;
  logic [8:0] byte_count;
  logic [7:0] held0;
  logic [7:0] held1;
  logic [7:0] first_byte;

  logic       mode_cur;
  logic [8:0] count_cur;
  logic [7:0] held0_cur;
  logic [7:0] held1_cur;
  logic [7:0] first_cur;
  logic [8:0] count_next;
  logic [7:0] first_byte_next;

  always_comb begin
    // a new frame starts from cleared state
    mode_cur  = in_frame ? frame_mode : item.command;
    count_cur = in_frame ? byte_count : 9'd0;
    held0_cur = in_frame ? held0 : 8'h00;
    held1_cur = in_frame ? held1 : 8'h00;
    first_cur = in_frame ? first_byte : 8'h00;

    count_next      = (count_cur == COUNT_SAT) ? count_cur : count_cur + 9'd1;
    first_byte_next = (count_cur == 9'd0) ? item.data_byte : first_cur;

    job.mode       = mode_cur;
    job.first      = !in_frame;
    job.last       = item.last_item;
    job.data       = item.data_byte;
    job.uid        = item.unit_id;
    job.count      = count_next;
    job.feed_en    = (count_cur >= 9'd2);
    job.feed_byte  = held0_cur;
    job.rx_crc     = {item.data_byte, held1_cur};
    job.first_byte = first_byte_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame   <= 1'b0;
      frame_mode <= CMD_ENCODE;
      byte_count <= 9'd0;
    end else if (accept) begin
      in_frame   <= !item.last_item;
      frame_mode <= mode_cur;
      byte_count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held0      <= held1_cur;
      held1      <= item.data_byte;
      first_byte <= first_byte_next;
    end
  end

endmodule

// File: src/mrtu_fifo.sv
// ----------------------------------------------------------------------------
// mrtu_fifo
// Short job queue between front and back end.
// ----------------------------------------------------------------------------
module mrtu_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  mrtu_pkg::job_t push_job,
  input  logic           pop,
  output mrtu_pkg::job_t pop_job,
  output logic           full,
  output logic           not_empty
);
  import mrtu_pkg::*;

  job_t                mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_CW-1:0] fill;

  assign full      = (fill == QUEUE_CW'(QUEUE_DEPTH));
  assign not_empty = (fill != '0);
  assign pop_job   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QUEUE_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QUEUE_AW'(1);
      end
      if (push && !pop) begin
        fill <= fill + QUEUE_CW'(1);
      end else if (pop && !push) begin
        fill <= fill - QUEUE_CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

endmodule

// File: src/mrtu_back.sv
// ----------------------------------------------------------------------------
// mrtu_back
// Runs queued jobs: crc update, byte emission and end-of-frame checks.
// ----------------------------------------------------------------------------
module mrtu_back (
  input  logic                clk,
  input  logic                rst,
  input  logic [8:0]          capacity,
  input  logic                job_valid,
  input  mrtu_pkg::job_t      job,
  output logic                job_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output mrtu_pkg::out_item_t out_item
);
  import mrtu_pkg::*;

  localparam logic [2:0] P_UID   = 3'd0;
  localparam logic [2:0] P_DATA  = 3'd1;
  localparam logic [2:0] P_END   = 3'd2;
  localparam logic [2:0] P_HI    = 3'd3;
  localparam logic [2:0] P_DFEED = 3'd4;
  localparam logic [2:0] P_DEND  = 3'd5;

  job_t        cur;
  logic        busy;
  logic [2:0]  phase;
  logic [15:0] crc;

  logic        can_emit;
  logic        emits;
  logic        step;
  logic        finish;
  logic        emit;
  out_item_t   out_next;
  logic [15:0] crc_next;
  logic [2:0]  phase_next;
  logic [2:0]  start_phase;
  logic [15:0] dec_base;

  assign can_emit = !out_valid || !out_stall;
  assign emits    = (phase != P_DFEED);
  assign step     = busy && (!emits || can_emit);
  assign dec_base = cur.first ? CRC_INIT : crc;

  always_comb begin
    out_next   = '0;
    crc_next   = crc;
    phase_next = phase;
    finish     = 1'b0;
    case (phase)
      P_UID: begin
        out_next.out_byte = cur.uid;
        crc_next          = crc_feed(CRC_INIT, cur.uid);
        phase_next        = P_DATA;
      end
      P_DATA: begin
        out_next.out_byte = cur.data;
        crc_next          = crc_feed(crc, cur.data);
        phase_next        = P_END;
        finish            = !cur.last;
      end
      P_END: begin
        if (cur.count == 9'd0 || cur.count > 9'(PDU_MAX)) begin
          out_next.run_last = 1'b1;
          out_next.status   = ST_LEN;
          finish            = 1'b1;
        end else if ({1'b0, cur.count} + 10'd3 > {1'b0, capacity}) begin
          out_next.run_last = 1'b1;
          out_next.status   = ST_CAP;
          finish            = 1'b1;
        end else begin
          out_next.out_byte = crc[7:0];
          phase_next        = P_HI;
        end
      end
      P_HI: begin
        out_next.out_byte = crc[15:8];
        out_next.run_last = 1'b1;
        finish            = 1'b1;
      end
      P_DFEED: begin
        crc_next   = cur.feed_en ? crc_feed(dec_base, cur.feed_byte) : dec_base;
        phase_next = P_DEND;
        finish     = !cur.last;
      end
      P_DEND: begin
        out_next.run_last = 1'b1;
        if (cur.count < 9'(ADU_MIN) || cur.count > 9'(ADU_MAX)) begin
          out_next.status = ST_LEN;
        end else if (cur.rx_crc != crc) begin
          out_next.status = ST_CRC;
        end else begin
          out_next.status           = ST_OK;
          out_next.frame_unit_id    = cur.first_byte;
          out_next.frame_pdu_length = 8'(cur.count - 9'd3);
        end
        finish = 1'b1;
      end
      default: begin
        finish = 1'b1;
      end
    endcase
    finish = finish && step;
    emit   = step && emits;
  end

  always_comb begin
    if (job.mode == CMD_DECODE) begin
      start_phase = P_DFEED;
    end else if (job.first) begin
      start_phase = P_UID;
    end else begin
      start_phase = P_DATA;
    end
  end

  assign job_pop = job_valid && (!busy || finish);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      phase     <= P_UID;
      crc       <= CRC_INIT;
      out_valid <= 1'b0;
    end else begin
      if (step) begin
        crc <= crc_next;
      end
      if (job_pop) begin
        busy  <= 1'b1;
        phase <= start_phase;
      end else if (finish) begin
        busy <= 1'b0;
      end else if (step) begin
        phase <= phase_next;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      cur <= job;
    end
    if (emit) begin
      out_item <= out_next;
    end
  end

endmodule

// File: src/modbus_rtu_frame_codec.sv
// ----------------------------------------------------------------------------
// modbus_rtu_frame_codec
// Modbus rtu framer and deframer with crc-16/modbus on a byte stream.
// ----------------------------------------------------------------------------
// A byte is taken every cycle while the four-entry job queue has room. The
// back-end sequencer gives at most one result per cycle while the output is
// not stalled: an encode byte gives one result, two on the first byte of a
// frame (unit id first), and two more on the last byte (crc low and high, or
// one error result). A decode byte gives only a crc update, and its last
// byte gives the frame status after the final crc update. The sustained
// rate is set by steps per byte, and output stalls only back up the queue.
// ----------------------------------------------------------------------------
module modbus_rtu_frame_codec (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write_en,
  input  logic [8:0]          cfg_write_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  mrtu_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output mrtu_pkg::out_item_t out_item
);
  import mrtu_pkg::*;

  logic [8:0] output_capacity;
  logic       in_accept;
  job_t       front_job;
  job_t       queue_job;
  logic       queue_full;
  logic       queue_valid;
  logic       queue_pop;

  assign in_stall  = queue_full;
  assign in_accept = in_valid && !queue_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      output_capacity <= CAP_RESET;
    end else if (cfg_write_en) begin
      output_capacity <= cfg_write_data;
    end
  end

  mrtu_front u_front (
    .clk    (clk),
    .rst    (rst),
    .accept (in_accept),
    .item   (in_item),
    .job    (front_job)
  );

  mrtu_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (in_accept),
    .push_job  (front_job),
    .pop       (queue_pop),
    .pop_job   (queue_job),
    .full      (queue_full),
    .not_empty (queue_valid)
  );

  mrtu_back u_back (
    .clk       (clk),
    .rst       (rst),
    .capacity  (output_capacity),
    .job_valid (queue_valid),
    .job       (queue_job),
    .job_pop   (queue_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

// File: src/mrtu_checker.sv
// ----------------------------------------------------------------------------
// mrtu_checker
// Port-level checks on the codec result channel.
// ----------------------------------------------------------------------------
module mrtu_checker (
  input logic                clk,
  input logic                rst,
  input logic                out_valid,
  input logic                out_stall,
  input mrtu_pkg::out_item_t out_item
);
  import mrtu_pkg::*;

  // no result right after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // a stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result changed");

  // error status only closes a frame
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.status != ST_OK |-> out_item.run_last && out_item.out_byte == 8'h00)
    else $error("error status on a non-final result");

  // decode fields only on a final ok status result
  a_dec_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_item.frame_pdu_length != 8'h00 || out_item.frame_unit_id != 8'h00)
    |-> out_item.run_last && out_item.status == ST_OK && out_item.out_byte == 8'h00)
    else $error("decode fields on wrong result");

endmodule

bind modbus_rtu_frame_codec mrtu_checker u_mrtu_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);

// File: sim/tb_modbus_rtu_frame_codec.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_modbus_rtu_frame_codec
// Self-checking bench for the modbus rtu framer / deframer. Whole encode and
// decode frames are queued, driven with random gaps and output stalls, and
// every result is compared against a cycle-free predictor of the codec.
// ----------------------------------------------------------------------------
module tb_modbus_rtu_frame_codec;
  import mrtu_pkg::*;

  localparam int SETTLE_CYCLES  = 16;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int MAX_PRINTED    = 50;

  // kinds of decode frame the stimulus can build
  localparam int FR_GOOD = 0;
  localparam int FR_BAD  = 1;
  localparam int FR_RAW  = 2;

  typedef struct {
    in_item_t item;
    logic     drain;
  } feed_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_write_en = 1'b0;
  logic [8:0] cfg_write_data = '0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  in_item_t   in_item = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_item_t  out_item;

  feed_t     tx_bytes_q[$];
  out_item_t frame_results_q[$];

  // predictor state
  logic        fr_open = 1'b0;
  logic        fr_mode = CMD_ENCODE;
  logic [8:0]  fr_count = '0;
  logic [15:0] fr_crc = CRC_INIT;
  logic [7:0]  hold0 = '0;
  logic [7:0]  hold1 = '0;
  logic [7:0]  fr_first = '0;
  logic [8:0]  cap_bytes = CAP_RESET;

  int mismatches = 0;
  int bytes_queued = 0;
  int bytes_taken = 0;
  int results_seen = 0;
  int enc_frames = 0;
  int dec_frames = 0;
  int status_seen[4] = '{0, 0, 0, 0};
  int in_gap = 0;
  int out_hold = 0;
  int idle_cycles = 0;
  bit quiet_in = 1'b0;
  bit quiet_out = 1'b0;

  modbus_rtu_frame_codec DUT (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_item        (in_item),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_item       (out_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [15:0] crc16_byte(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {8'h00, b};
    repeat (8) begin
      r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

  function automatic void add_result(input logic [7:0] b, input logic last,
                                     input logic [1:0] st, input logic [7:0] uid,
                                     input logic [7:0] plen);
    out_item_t r;
    r.out_byte         = b;
    r.run_last         = last;
    r.status           = st;
    r.frame_unit_id    = uid;
    r.frame_pdu_length = plen;
    frame_results_q.push_back(r);
  endfunction

  // expected results for one accepted byte
  task automatic predict_frame_byte(input in_item_t it);
    logic [8:0] plen;
    if (!fr_open) begin
      fr_open  = 1'b1;
      fr_mode  = it.command;
      fr_count = '0;
      fr_crc   = CRC_INIT;
      hold0    = '0;
      hold1    = '0;
      fr_first = '0;
      if (fr_mode == CMD_ENCODE) begin
        fr_crc = crc16_byte(fr_crc, it.unit_id);
        add_result(it.unit_id, 1'b0, ST_OK, 8'h00, 8'h00);
      end
    end
    if (fr_mode == CMD_ENCODE) begin
      fr_crc = crc16_byte(fr_crc, it.data_byte);
      if (fr_count != COUNT_SAT) fr_count = fr_count + 9'd1;
      add_result(it.data_byte, 1'b0, ST_OK, 8'h00, 8'h00);
      if (it.last_item) begin
        if (int'(fr_count) > PDU_MAX) begin
          add_result(8'h00, 1'b1, ST_LEN, 8'h00, 8'h00);
        end else if (int'(fr_count) + 3 > int'(cap_bytes)) begin
          add_result(8'h00, 1'b1, ST_CAP, 8'h00, 8'h00);
        end else begin
          add_result(fr_crc[7:0], 1'b0, ST_OK, 8'h00, 8'h00);
          add_result(fr_crc[15:8], 1'b1, ST_OK, 8'h00, 8'h00);
        end
        fr_open = 1'b0;
      end
    end else begin
      if (fr_count == 9'd0) fr_first = it.data_byte;
      // the crc trails by two bytes so the received crc never enters it
      if (fr_count >= 9'd2) fr_crc = crc16_byte(fr_crc, hold0);
      hold0 = hold1;
      hold1 = it.data_byte;
      if (fr_count != COUNT_SAT) fr_count = fr_count + 9'd1;
      if (it.last_item) begin
        plen = fr_count - 9'd3;
        if (int'(fr_count) < ADU_MIN || int'(fr_count) > ADU_MAX) begin
          add_result(8'h00, 1'b1, ST_LEN, 8'h00, 8'h00);
        end else if ({hold1, hold0} != fr_crc) begin
          add_result(8'h00, 1'b1, ST_CRC, 8'h00, 8'h00);
        end else begin
          add_result(8'h00, 1'b1, ST_OK, fr_first, plen[7:0]);
        end
        fr_open = 1'b0;
      end
    end
  endtask

  task automatic report_mismatch(input string msg);
    mismatches++;
    // keep the log short when the design is badly broken
    if (mismatches <= MAX_PRINTED) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (frame_results_q.size() == 0) begin
      report_mismatch($sformatf("result %0d arrived with nothing pending (byte %02h status %0d)",
                                results_seen, got.out_byte, got.status));
    end else begin
      want = frame_results_q.pop_front();
      if (got.out_byte !== want.out_byte)
        report_mismatch($sformatf("result %0d out_byte %02h, wanted %02h",
                                  results_seen, got.out_byte, want.out_byte));
      if (got.run_last !== want.run_last)
        report_mismatch($sformatf("result %0d run_last %0b, wanted %0b",
                                  results_seen, got.run_last, want.run_last));
      if (got.status !== want.status)
        report_mismatch($sformatf("result %0d status %0d, wanted %0d",
                                  results_seen, got.status, want.status));
      if (got.frame_unit_id !== want.frame_unit_id)
        report_mismatch($sformatf("result %0d frame_unit_id %02h, wanted %02h",
                                  results_seen, got.frame_unit_id, want.frame_unit_id));
      if (got.frame_pdu_length !== want.frame_pdu_length)
        report_mismatch($sformatf("result %0d frame_pdu_length %0d, wanted %0d",
                                  results_seen, got.frame_pdu_length, want.frame_pdu_length));
    end
  endtask

  // byte driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_frame_byte(in_item);
        bytes_taken++;
        in_gap = quiet_in ? 0 : $urandom_range(0, 14);
        if ($urandom_range(0, 24) == 0) quiet_in = !quiet_in;
      end
      if (!in_valid || !in_stall) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (tx_bytes_q.size() != 0 &&
                     !(tx_bytes_q[0].drain && frame_results_q.size() != 0)) begin
          in_item  <= tx_bytes_q[0].item;
          in_valid <= 1'b1;
          void'(tx_bytes_q.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        check_result(out_item);
        if (out_item.run_last) status_seen[out_item.status]++;
        results_seen++;
        out_hold = quiet_out ? 0 : $urandom_range(0, 14);
        if ($urandom_range(0, 29) == 0) quiet_out = !quiet_out;
      end else if (!out_valid && out_hold == 0 && !quiet_out && $urandom_range(0, 7) == 0) begin
        out_hold = $urandom_range(1, 14);
      end
      if (out_hold > 0) begin
        out_hold--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // a stretch with no transaction on either side means the codec hung
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[%0t] timeout: no transaction for %0d cycles, %0d results pending",
               $time, idle_cycles, frame_results_q.size());
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic queue_byte(input logic cmd, input logic [7:0] b, input logic [7:0] uid,
                            input logic last);
    feed_t f;
    f.item.command   = cmd;
    f.item.data_byte = b;
    f.item.unit_id   = uid;
    f.item.last_item = last;
    f.drain          = ($urandom_range(0, 39) == 0);
    tx_bytes_q.push_back(f);
    bytes_queued++;
  endtask

  // uid or fill below zero means random
  task automatic queue_encode(input int uid, input int len, input int fill, input bit flip);
    logic [7:0] b;
    logic [7:0] u;
    logic       cmd;
    for (int i = 0; i < len; i++) begin
      b   = (fill < 0) ? 8'($urandom) : 8'(fill);
      u   = (i == 0 && uid >= 0) ? 8'(uid) : 8'($urandom);
      cmd = (i != 0 && flip && $urandom_range(0, 1)) ? CMD_DECODE : CMD_ENCODE;
      queue_byte(cmd, b, u, i == len - 1);
    end
    enc_frames++;
  endtask

  task automatic queue_decode(input int len, input int kind, input int first, input bit flip);
    logic [7:0]  fb[$];
    logic [15:0] c;
    logic        cmd;
    int          k;
    for (int i = 0; i < len; i++) fb.push_back((i == 0 && first >= 0) ? 8'(first) : 8'($urandom));
    if (kind != FR_RAW && len >= 2) begin
      c = CRC_INIT;
      for (int i = 0; i < len - 2; i++) c = crc16_byte(c, fb[i]);
      fb[len - 2] = c[7:0];
      fb[len - 1] = c[15:8];
    end
    if (kind == FR_BAD) begin
      k = $urandom_range(0, len - 1);
      fb[k] = fb[k] ^ (8'h01 << $urandom_range(0, 7));
    end
    for (int i = 0; i < len; i++) begin
      cmd = (i != 0 && flip && $urandom_range(0, 1)) ? CMD_ENCODE : CMD_DECODE;
      queue_byte(cmd, fb[i], 8'($urandom), i == len - 1);
    end
    dec_frames++;
  endtask

  // mostly short well-formed frames, some corrupt and some noise
  task automatic random_frames(input int n);
    int start;
    int kind;
    int len;
    start = bytes_queued;
    while (bytes_queued - start < n) begin
      kind = $urandom_range(0, 9);
      len  = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
      if (kind < 4) queue_encode(-1, len, -1, $urandom_range(0, 3) == 0);
      else if (kind < 8) queue_decode(len + 3, FR_GOOD, -1, $urandom_range(0, 3) == 0);
      else if (kind == 8) queue_decode(len + 3, FR_BAD, -1, 1'b0);
      else queue_decode(len, FR_RAW, -1, 1'b1);
    end
  endtask

  // wait for every result plus a margin for decode bytes still in flight
  task automatic settle();
    do @(negedge clk);
    while (tx_bytes_q.size() != 0 || in_valid || frame_results_q.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_capacity(input logic [8:0] v);
    @(posedge clk);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= v;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    cap_bytes = v;
    @(negedge clk);
  endtask

  initial begin
    // short directed frames at the reset capacity
    queue_encode(8'h00, 1, 8'h00, 1'b0);
    queue_encode(8'hFF, 1, 8'hFF, 1'b0);
    queue_encode(8'h5A, 3, -1, 1'b1);
    tx_bytes_q[tx_bytes_q.size() - 2].drain = 1'b1;
    queue_decode(ADU_MIN, FR_GOOD, 8'h00, 1'b0);
    queue_decode(5, FR_GOOD, 8'hFF, 1'b1);
    queue_decode(3, FR_GOOD, -1, 1'b0);
    queue_decode(1, FR_RAW, -1, 1'b0);
    queue_decode(2, FR_GOOD, -1, 1'b0);
    queue_decode(6, FR_BAD, -1, 1'b0);
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    settle();

    set_capacity(9'd0);
    queue_encode(-1, 1, -1, 1'b0);
    queue_decode(ADU_MIN, FR_GOOD, -1, 1'b0);
    random_frames(25);
    settle();

    set_capacity(9'd4);
    queue_encode(-1, 1, -1, 1'b0);
    queue_encode(-1, 2, -1, 1'b0);
    random_frames(25);
    settle();

    set_capacity(9'h1FF);
    random_frames(25);
    settle();

    // small capacity so that short encode frames hit both outcomes
    set_capacity(9'($urandom_range(5, 20)));
    random_frames(30);
    settle();

    if (frame_results_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", frame_results_q.size()));
    $display("sent %0d bytes in %0d encode and %0d decode frames, checked %0d results",
             bytes_taken, enc_frames, dec_frames, results_seen);
    $display("final results by status: ok %0d, length %0d, capacity %0d, crc %0d",
             status_seen[ST_OK], status_seen[ST_LEN], status_seen[ST_CAP], status_seen[ST_CRC]);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/mrtu_pkg.sv
src/mrtu_front.sv
src/mrtu_fifo.sv
src/mrtu_back.sv
src/modbus_rtu_frame_codec.sv
src/mrtu_checker.sv
sim/tb_modbus_rtu_frame_codec.sv
